/* hw/rtl/igen_pkg.sv */
// Shared types, codes and sizes for the integer partition generator.
`timescale 1ns / 1ps

package igen_pkg;

  // Width of a part, of the target and of every stored entry.
  localparam int unsigned PART_W = 6;
  // Signed store index; holds -2 .. 63 for every supported store size.
  localparam int unsigned IDX_W = 8;
  // Default largest target.
  localparam int unsigned MAX_N_DEF = 32;

  typedef enum logic [0:0] {
    FUNC_START = 1'b0,
    FUNC_NEXT  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_PART  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DONE  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SINGLE,
    S_EMIT,
    S_ADV,
    S_ZERO2,
    S_RDREF,
    S_RDLAST,
    S_WALK,
    S_FIX1,
    S_FIX2,
    S_FIX3,
    S_CHK,
    S_CHK2
  } ctrl_state_e;

  // Access request from the sequencer to the parts store.
  typedef struct packed {
    logic                     clr;
    logic                     we;
    logic signed [IDX_W-1:0]  waddr;
    logic [PART_W-1:0]        wdata;
    logic                     re;
    logic signed [IDX_W-1:0]  raddr;
  } store_req_t;

  // Result item handed to the output register.
  typedef struct packed {
    logic              load;
    logic [PART_W-1:0] part;
    status_e           status;
    logic              last;
    logic              fin;
  } out_item_t;

endpackage

/* hw/rtl/igen_in_if.sv */
// Request channel: start or advance, with the target.
`timescale 1ns / 1ps

interface igen_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [igen_pkg::PART_W-1:0]   target;

  modport source (output valid, output func, output target, input ready);
  modport sink   (input valid, input func, input target, output ready);
endinterface

/* hw/rtl/igen_out_if.sv */
// Result channel: one part of a partition, or a status, per item.
`timescale 1ns / 1ps

interface igen_out_if;
  logic                          valid;
  logic                          ready;
  logic [igen_pkg::PART_W-1:0]   part;
  logic [1:0]                    status;
  logic                          last_part;
  logic                          final_partition;

  modport source (output valid, output part, output status, output last_part,
                  output final_partition, input ready);
  modport sink   (input valid, input part, input status, input last_part,
                  input final_partition, output ready);
endinterface

/* hw/rtl/igen_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module igen_ram #(
  parameter int unsigned WIDTH = igen_pkg::PART_W,
  parameter int unsigned DEPTH = igen_pkg::MAX_N_DEF + 1,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and read through a registered output; the read data holds when idle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/igen_store.sv */
// Parts store: RAM with per-entry valid bits; unwritten or out-of-range entries read as one.
`timescale 1ns / 1ps

module igen_store #(
  parameter int unsigned MAX_N = igen_pkg::MAX_N_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  igen_pkg::store_req_t          req_i,
  output logic [igen_pkg::PART_W-1:0]   rdata_o
);

  localparam int unsigned DEPTH = MAX_N + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [DEPTH-1:0]              valid_q;
  logic                          rfix_q;
  logic                          we_ok;
  logic                          re_ok;
  logic [AW-1:0]                 waddr_a;
  logic [AW-1:0]                 raddr_a;
  logic                          rvld;
  logic [igen_pkg::PART_W-1:0]   ram_rdata;

  function automatic logic in_range(logic signed [igen_pkg::IDX_W-1:0] idx);
    in_range = (idx >= 0) && (idx <= $signed(igen_pkg::IDX_W'(MAX_N)));
  endfunction

  assign we_ok   = req_i.we && in_range(req_i.waddr);
  assign re_ok   = req_i.re && in_range(req_i.raddr);
  assign waddr_a = req_i.waddr[AW-1:0];
  assign raddr_a = req_i.raddr[AW-1:0];
  assign rvld    = re_ok && valid_q[raddr_a];

  igen_ram #(
    .WIDTH (igen_pkg::PART_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_ok),
    .waddr_i (waddr_a),
    .wdata_i (req_i.wdata),
    .re_i    (re_ok),
    .raddr_i (raddr_a),
    .rdata_o (ram_rdata)
  );

  // Valid bits: cleared at once on a start, set by each write.
  // The read side notes whether the entry read must be replaced by one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rfix_q  <= 1'b1;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (we_ok) begin
        valid_q[waddr_a] <= 1'b1;
      end
      if (req_i.re) begin
        rfix_q <= !rvld;
      end
    end
  end

  assign rdata_o = rfix_q ? igen_pkg::PART_W'(1) : ram_rdata;

endmodule

/* hw/rtl/igen_ctrl.sv */
// Sequencer: start handling, successor step over the parts store and part emission.
`timescale 1ns / 1ps

module igen_ctrl #(
  parameter int unsigned MAX_N = igen_pkg::MAX_N_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_func_i,
  input  logic [igen_pkg::PART_W-1:0]   in_target_i,
  output logic                          in_ready_o,
  input  logic                          out_free_i,
  output igen_pkg::out_item_t           item_o,
  output igen_pkg::store_req_t          sreq_o,
  input  logic [igen_pkg::PART_W-1:0]   rdata_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_N + 1);
  localparam int unsigned IDX_W  = igen_pkg::IDX_W;
  localparam int unsigned PART_W = igen_pkg::PART_W;
  localparam int unsigned PROD_W = PART_W + IDX_W;
  localparam int unsigned SW     = PROD_W + 2;

  igen_pkg::ctrl_state_e state_q, state_d;
  logic [CNT_W-1:0]          h_q, h_d;
  logic [CNT_W-1:0]          m_q, m_d;
  logic [CNT_W-1:0]          tgt_q, tgt_d;
  logic                      run_q, run_d;
  logic                      fin_q, fin_d;
  igen_pkg::status_e         sst_q, sst_d;
  logic signed [IDX_W-1:0]   j_q, j_d;
  logic signed [IDX_W-1:0]   hs_q, hs_d;
  logic [PART_W-1:0]         ref_q, ref_d;
  logic [PART_W-1:0]         rm_q, rm_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [CNT_W-1:0]          e_q, e_d;
  logic                      pend_q, pend_d;

  logic                      accept;
  logic                      load;
  logic signed [IDX_W-1:0]   m_s;
  logic signed [IDX_W-1:0]   h_s;
  logic signed [IDX_W-1:0]   mh1;
  logic signed [SW-1:0]      r_s;
  logic signed [SW-1:0]      mn_s;
  logic [CNT_W-1:0]          n_clamp;

  function automatic logic signed [SW-1:0] sx(logic signed [IDX_W-1:0] v);
    sx = {{(SW-IDX_W){v[IDX_W-1]}}, v};
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cnt(logic signed [SW-1:0] v);
    if (v < 0) begin
      clamp_cnt = '0;
    end else if (v > $signed(SW'(MAX_N))) begin
      clamp_cnt = CNT_W'(MAX_N);
    end else begin
      clamp_cnt = v[CNT_W-1:0];
    end
  endfunction

  assign m_s     = $signed(IDX_W'(m_q));
  assign h_s     = $signed(IDX_W'(h_q));
  assign mh1     = m_s - hs_q - IDX_W'(1);
  assign r_s     = $signed(SW'(rm_q)) + $signed(SW'(prod_q));
  assign mn_s    = sx(hs_q) + r_s - SW'(1);
  assign n_clamp = (in_target_i > PART_W'(MAX_N)) ? CNT_W'(MAX_N)
                                                   : in_target_i[CNT_W-1:0];

  assign in_ready_o = (state_q == igen_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = pend_q && out_free_i;

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= igen_pkg::S_IDLE;
      h_q     <= '0;
      m_q     <= '0;
      tgt_q   <= '0;
      run_q   <= 1'b0;
      fin_q   <= 1'b0;
      sst_q   <= igen_pkg::ST_PART;
      e_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      m_q     <= m_d;
      tgt_q   <= tgt_d;
      run_q   <= run_d;
      fin_q   <= fin_d;
      sst_q   <= sst_d;
      e_q     <= e_d;
      pend_q  <= pend_d;
    end
  end

  // Datapath scratch values of the successor step.
  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    hs_q   <= hs_d;
    ref_q  <= ref_d;
    rm_q   <= rm_d;
    prod_q <= prod_d;
  end

  // Next state, store accesses and result items.
  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    m_d     = m_q;
    tgt_d   = tgt_q;
    run_d   = run_q;
    fin_d   = fin_q;
    sst_d   = sst_q;
    j_d     = j_q;
    hs_d    = hs_q;
    ref_d   = ref_q;
    rm_d    = rm_q;
    prod_d  = prod_q;
    e_d     = e_q;
    pend_d  = pend_q;
    sreq_o  = '0;
    item_o  = '0;

    unique case (state_q)
      igen_pkg::S_IDLE: begin
        if (accept) begin
          if (igen_pkg::func_e'(in_func_i) == igen_pkg::FUNC_START) begin
            // Start: every entry back to one, length is the target clamped to MAX_N.
            sreq_o.clr = 1'b1;
            tgt_d      = n_clamp;
            h_d        = '0;
            m_d        = n_clamp;
            e_d        = '0;
            pend_d     = 1'b0;
            if (n_clamp == '0) begin
              run_d   = 1'b0;
              fin_d   = 1'b1;
              sst_d   = igen_pkg::ST_EMPTY;
              state_d = igen_pkg::S_SINGLE;
            end else if (n_clamp == CNT_W'(1)) begin
              run_d   = 1'b0;
              fin_d   = 1'b1;
              state_d = igen_pkg::S_EMIT;
            end else begin
              run_d   = 1'b1;
              fin_d   = 1'b0;
              state_d = igen_pkg::S_EMIT;
            end
          end else if (!run_q) begin
            fin_d   = 1'b0;
            sst_d   = igen_pkg::ST_DONE;
            state_d = igen_pkg::S_SINGLE;
          end else begin
            state_d = igen_pkg::S_ADV;
          end
        end
      end

      igen_pkg::S_SINGLE: begin
        item_o.load   = out_free_i;
        item_o.status = sst_q;
        item_o.last   = 1'b1;
        item_o.fin    = fin_q;
        if (out_free_i) begin
          state_d = igen_pkg::S_IDLE;
        end
      end

      igen_pkg::S_EMIT: begin
        // Read data for entry e_q is waiting; the next read is issued as it leaves.
        item_o.load   = load;
        item_o.part   = rdata_i;
        item_o.status = igen_pkg::ST_PART;
        item_o.last   = (e_q == m_q);
        item_o.fin    = fin_q;
        if (!pend_q || load) begin
          if (e_q < m_q) begin
            sreq_o.re    = 1'b1;
            sreq_o.raddr = $signed(IDX_W'(e_q)) + IDX_W'(1);
            e_d          = e_q + 1'b1;
            pend_d       = 1'b1;
          end else begin
            pend_d  = 1'b0;
            state_d = igen_pkg::S_IDLE;
          end
        end
      end

      igen_pkg::S_ADV: begin
        if (h_q == '0) begin
          // First step after the all-ones partition.
          sreq_o.we    = 1'b1;
          sreq_o.waddr = '0;
          sreq_o.wdata = PART_W'(1);
          state_d      = igen_pkg::S_ZERO2;
        end else if (m_s - h_s > 1) begin
          // Room behind the tail: append a two and shorten.
          sreq_o.we    = 1'b1;
          sreq_o.waddr = h_s + IDX_W'(1);
          sreq_o.wdata = PART_W'(2);
          h_d          = h_q + 1'b1;
          m_d          = m_q - 1'b1;
          state_d      = igen_pkg::S_CHK;
        end else begin
          sreq_o.re    = 1'b1;
          sreq_o.raddr = m_s - IDX_W'(1);
          state_d      = igen_pkg::S_RDREF;
        end
      end

      igen_pkg::S_ZERO2: begin
        sreq_o.we    = 1'b1;
        sreq_o.waddr = IDX_W'(1);
        sreq_o.wdata = PART_W'(2);
        h_d          = CNT_W'(1);
        m_d          = tgt_q - 1'b1;
        state_d      = igen_pkg::S_CHK;
      end

      igen_pkg::S_RDREF: begin
        ref_d        = rdata_i;
        sreq_o.re    = 1'b1;
        sreq_o.raddr = m_s;
        state_d      = igen_pkg::S_RDLAST;
      end

      igen_pkg::S_RDLAST: begin
        rm_d         = rdata_i;
        j_d          = m_s - IDX_W'(2);
        sreq_o.re    = 1'b1;
        sreq_o.raddr = m_s - IDX_W'(2);
        state_d      = igen_pkg::S_WALK;
      end

      igen_pkg::S_WALK: begin
        // Walk back over parts equal to the reference, one entry a cycle.
        if ((j_q >= 0) && (rdata_i == ref_q)) begin
          sreq_o.we    = 1'b1;
          sreq_o.waddr = j_q;
          sreq_o.wdata = PART_W'(1);
          sreq_o.re    = 1'b1;
          sreq_o.raddr = j_q - IDX_W'(1);
          j_d          = j_q - IDX_W'(1);
        end else begin
          hs_d    = j_q + IDX_W'(1);
          state_d = igen_pkg::S_FIX1;
        end
      end

      igen_pkg::S_FIX1: begin
        // Bump the new tail and form the remainder product.
        sreq_o.we    = 1'b1;
        sreq_o.waddr = hs_q;
        sreq_o.wdata = ref_q + 1'b1;
        prod_d       = PROD_W'(ref_q) * PROD_W'($unsigned(mh1));
        state_d      = igen_pkg::S_FIX2;
      end

      igen_pkg::S_FIX2: begin
        if (m_s - hs_q > 1) begin
          sreq_o.we    = 1'b1;
          sreq_o.waddr = m_s - IDX_W'(1);
          sreq_o.wdata = PART_W'(1);
        end
        state_d = igen_pkg::S_FIX3;
      end

      igen_pkg::S_FIX3: begin
        sreq_o.we    = 1'b1;
        sreq_o.waddr = m_s;
        sreq_o.wdata = PART_W'(1);
        h_d          = clamp_cnt(sx(hs_q));
        m_d          = clamp_cnt(mn_s);
        state_d      = igen_pkg::S_CHK;
      end

      igen_pkg::S_CHK: begin
        sreq_o.re    = 1'b1;
        sreq_o.raddr = IDX_W'(1);
        state_d      = igen_pkg::S_CHK2;
      end

      igen_pkg::S_CHK2: begin
        // The partition made of the target alone ends the enumeration.
        e_d    = '0;
        pend_d = 1'b0;
        if ((rdata_i == PART_W'(tgt_q)) || (m_q == '0)) begin
          run_d = 1'b0;
          if (m_q == '0) begin
            fin_d   = 1'b0;
            sst_d   = igen_pkg::ST_DONE;
            state_d = igen_pkg::S_SINGLE;
          end else begin
            fin_d   = 1'b1;
            state_d = igen_pkg::S_EMIT;
          end
        end else begin
          fin_d   = 1'b0;
          state_d = igen_pkg::S_EMIT;
        end
      end

      default: begin
        state_d = igen_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/integer_partition_generator.sv */
// Top level of the integer partition generator: channels, output register, checks.
`timescale 1ns / 1ps

// Lists the partitions of a target n in ZS2 order, one part per result item.
// in_i carries func (start or next) and target; out_o carries part, status,
// last_part and final_partition. A start loads min(target, MAX_N) and emits
// n ones; each next emits the following partition, ending with {n}. A target
// of zero yields one empty-partition item; a next after the end, or before
// any start, yields one exhausted item.
// A start emits its parts one per cycle while the receiver takes them. A next
// first runs the successor step over the parts store, whose walk back over
// equal parts visits one entry per cycle through its single read port, and
// then emits its parts the same way. The block takes one item at a time; it
// is ready again as soon as the last result of an item sits in the output
// register.
// Reset empties the output register and marks every store entry as one via
// valid bits, so no clearing pass is needed. A stalled receiver holds the
// output register and pauses emission without losing parts.
module integer_partition_generator #(
  parameter int unsigned MAX_N = igen_pkg::MAX_N_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  igen_in_if.sink     in_i,
  igen_out_if.source  out_o
);

  igen_pkg::out_item_t           item;
  igen_pkg::store_req_t          sreq;
  logic [igen_pkg::PART_W-1:0]   rdata;
  logic                          out_free;
  logic                          ready;

  logic                          ov_q;
  logic [igen_pkg::PART_W-1:0]   opart_q;
  logic [1:0]                    ostat_q;
  logic                          olast_q;
  logic                          ofin_q;

  igen_ctrl #(
    .MAX_N (MAX_N)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_target_i (in_i.target),
    .in_ready_o  (ready),
    .out_free_i  (out_free),
    .item_o      (item),
    .sreq_o      (sreq),
    .rdata_i     (rdata)
  );

  igen_store #(
    .MAX_N (MAX_N)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sreq),
    .rdata_o (rdata)
  );

  assign in_i.ready = ready;
  assign out_free   = !ov_q || out_o.ready;

  // Output register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (item.load) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (item.load) begin
      opart_q <= item.part;
      ostat_q <= item.status;
      olast_q <= item.last;
      ofin_q  <= item.fin;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.part            = opart_q;
  assign out_o.status          = ostat_q;
  assign out_o.last_part       = olast_q;
  assign out_o.final_partition = ofin_q;

  // An accepted item always keeps the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while the previous one was still being handled");

  // While a part that is not the last waits, its run is still being emitted.
  a_run_in_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_part) |-> !in_i.ready)
    else $error("ready for a new request in the middle of a partition");

  // A start clear never coincides with a store write.
  a_clear_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sreq.clr |-> !sreq.we)
    else $error("store written in the cycle it is cleared");

endmodule
